/* hdl/change_triggered_frame_events_core_macros.svh */
`ifndef CHANGE_TRIGGERED_FRAME_EVENTS_CORE_MACROS_SVH
`define CHANGE_TRIGGERED_FRAME_EVENTS_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CTFE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CTFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ctfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ctfe_pkg;

   // Field widths of the transactions.
   localparam int REQ_TYPE_W    = 2;
   localparam int SLOT_W        = 6;
   localparam int SIGNAL_ID_W   = 32;
   localparam int VALUE_W       = 32;
   localparam int EVENT_INDEX_W = 4;
   localparam int OP_W          = 3;
   localparam int FRAME_ID_W    = 29;
   localparam int PAYLOAD_W     = 64;
   localparam int EVENT_COUNT_W = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   // Request types.
   localparam logic [REQ_TYPE_W-1:0] REQ_SAMPLE  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESTART = 2'd2;

   // Control register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_ERROR  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_COUNT = 2'd1;

   // Compare operations of an event entry.
   localparam logic [OP_W-1:0] OP_NE = 3'd0;
   localparam logic [OP_W-1:0] OP_EQ = 3'd1;
   localparam logic [OP_W-1:0] OP_LT = 3'd2;
   localparam logic [OP_W-1:0] OP_LE = 3'd3;
   localparam logic [OP_W-1:0] OP_GT = 3'd4;
   localparam logic [OP_W-1:0] OP_GE = 3'd5;

   // One event table entry as stored in the table memory.
   typedef struct packed {
      logic [SIGNAL_ID_W-1:0]    signal_id;
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] limit;
      logic [FRAME_ID_W-1:0]     frame_id;
      logic [PAYLOAD_W-1:0]      payload;
   } entry_type;

   // One history slot as stored in the slot memory.
   typedef struct packed {
      logic               first;
      logic [VALUE_W-1:0] value;
   } slot_type;

   // Datapath controls issued by the sequencer for the current step.
   typedef struct packed {
      logic accept;
      logic cnt_clr;
      logic cnt_inc;
      logic tbl_rd;
      logic tbl_wr;
      logic slot_rd;
      logic slot_wr;
      logic slot_clr;
      logic scan_init;
      logic eval;
      logic emit;
      logic wait_out;
   } ctrl_type;

   // Datapath status tested by the sequencer's jumps.
   typedef struct packed {
      logic req_fire;
      logic is_load;
      logic is_restart;
      logic skip;
      logic cnt_lt_n;
      logic no_match;
      logic no_emit;
      logic not_last;
      logic clr_more;
      logic out_free;
   } status_type;

   // Signed compare of a sample against an entry's limit.
   // Unused operation codes always hold.
   function automatic logic compare_holds(
      input logic [OP_W-1:0]           op,
      input logic signed [VALUE_W-1:0] value,
      input logic signed [VALUE_W-1:0] limit
   );
      logic holds;
      case (op)
         OP_NE:   holds = (value != limit);
         OP_EQ:   holds = (value == limit);
         OP_LT:   holds = (value < limit);
         OP_LE:   holds = (value <= limit);
         OP_GT:   holds = (value > limit);
         OP_GE:   holds = (value >= limit);
         default: holds = 1'b1;
      endcase
      return holds;
   endfunction

endpackage

`default_nettype wire

/* hdl/ctfe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/ctfe_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctfe_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  ctfe_pkg::status_type  status,
   output ctfe_pkg::ctrl_type    ctrl
);

   import ctfe_pkg::*;

   typedef logic [3:0] step_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_NO_FIRE,
      C_LOAD,
      C_RESTART,
      C_SKIP,
      C_CNT_LT_N,
      C_NO_MATCH,
      C_NO_EMIT,
      C_NOT_LAST,
      C_CLR_MORE
   } cond_type;

   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      step_type target;
   } ucode_type;

   // Program addresses.
   localparam step_type P_IDLE     = 4'd0;
   localparam step_type P_DISPATCH = 4'd1;
   localparam step_type P_RESTART  = 4'd2;
   localparam step_type P_FILTER   = 4'd3;
   localparam step_type P_SCAN0    = 4'd4;
   localparam step_type P_SCAN     = 4'd5;
   localparam step_type P_DECIDE   = 4'd6;
   localparam step_type P_HIST     = 4'd7;
   localparam step_type P_EMIT0    = 4'd8;
   localparam step_type P_EMIT     = 4'd9;
   localparam step_type P_DONE     = 4'd10;
   localparam step_type P_LOAD     = 4'd11;
   localparam step_type P_CLEAR    = 4'd12;
   localparam step_type P_CLEAR_END = 4'd13;

   // Control store. A step jumps to its target when its condition holds and
   // otherwise falls through to the next address.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      w.cond = C_ALWAYS;
      w.target = P_IDLE;
      case (step)
         P_IDLE: begin
            w.ctrl.accept  = 1'b1;
            w.ctrl.cnt_clr = 1'b1;
            w.cond         = C_NO_FIRE;
            w.target       = P_IDLE;
         end
         P_DISPATCH: begin
            w.cond   = C_LOAD;
            w.target = P_LOAD;
         end
         P_RESTART: begin
            w.cond   = C_RESTART;
            w.target = P_CLEAR;
         end
         P_FILTER: begin
            w.cond   = C_SKIP;
            w.target = P_IDLE;
         end
         P_SCAN0: begin
            w.ctrl.tbl_rd    = 1'b1;
            w.ctrl.slot_rd   = 1'b1;
            w.ctrl.cnt_inc   = 1'b1;
            w.ctrl.scan_init = 1'b1;
            w.cond           = C_NO_FIRE;
            w.target         = P_SCAN;
         end
         P_SCAN: begin
            w.ctrl.eval    = 1'b1;
            w.ctrl.tbl_rd  = 1'b1;
            w.ctrl.cnt_inc = 1'b1;
            w.cond         = C_CNT_LT_N;
            w.target       = P_SCAN;
         end
         P_DECIDE: begin
            w.cond   = C_NO_MATCH;
            w.target = P_IDLE;
         end
         P_HIST: begin
            w.ctrl.slot_wr = 1'b1;
            w.ctrl.cnt_clr = 1'b1;
            w.cond         = C_NO_EMIT;
            w.target       = P_IDLE;
         end
         P_EMIT0: begin
            w.ctrl.tbl_rd  = 1'b1;
            w.ctrl.cnt_inc = 1'b1;
            w.cond         = C_NO_FIRE;
            w.target       = P_EMIT;
         end
         P_EMIT: begin
            w.ctrl.wait_out = 1'b1;
            w.ctrl.emit     = 1'b1;
            w.ctrl.tbl_rd   = 1'b1;
            w.ctrl.cnt_inc  = 1'b1;
            w.cond          = C_NOT_LAST;
            w.target        = P_EMIT;
         end
         P_LOAD: begin
            w.ctrl.tbl_wr = 1'b1;
         end
         P_CLEAR: begin
            w.ctrl.slot_clr = 1'b1;
            w.ctrl.cnt_inc  = 1'b1;
            w.cond          = C_CLR_MORE;
            w.target        = P_CLEAR;
         end
         P_DONE, P_CLEAR_END: begin
            w.cond   = C_ALWAYS;
            w.target = P_IDLE;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = P_IDLE;
         end
      endcase
      return w;
   endfunction

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type word;
   logic      go;
   logic      taken;

   // Fetch, evaluate the jump condition, and hold the step while the output is busy.
   always_comb begin
      word = ucode_rom(pc_ff);
      go   = !word.ctrl.wait_out || status.out_free;
      case (word.cond)
         C_ALWAYS:   taken = 1'b1;
         C_NO_FIRE:  taken = !status.req_fire;
         C_LOAD:     taken = status.is_load;
         C_RESTART:  taken = status.is_restart;
         C_SKIP:     taken = status.skip;
         C_CNT_LT_N: taken = status.cnt_lt_n;
         C_NO_MATCH: taken = status.no_match;
         C_NO_EMIT:  taken = status.no_emit;
         C_NOT_LAST: taken = status.not_last;
         C_CLR_MORE: taken = status.clr_more;
         default:    taken = 1'b0;
      endcase
      if (!go) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
      ctrl = go ? word.ctrl : '0;
   end

   // Step counter; reset starts with a sweep over the history slots.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= P_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/change_triggered_frame_events_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Moves
// req_*     in         req_valid/req_ready  one sample, entry load or restart
// rsp_*     out        rsp_valid/rsp_ready  one frame per firing event entry
// csr_*     in         csr_valid/csr_ready  one control register write
//
// For a sample, one table pass finds matches and hits and a second one sends
// frames, one table read per cycle; the frame pass reads on only while the
// output register has room.
// After reset a sweep clears the slot history memory; no request
// transaction is taken during it.
// A stalled result holds the frame pass; the last result can wait in the
// output register while the next request transaction is taken.

module change_triggered_frame_events_core #(
   parameter int SLOT_COUNT  = 64,
   parameter int EVENT_COUNT = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ctfe_pkg::REQ_TYPE_W-1:0]         req_type,
   input  logic [ctfe_pkg::SLOT_W-1:0]             req_signal_slot,
   input  logic [ctfe_pkg::SIGNAL_ID_W-1:0]        req_signal_id,
   input  logic signed [ctfe_pkg::VALUE_W-1:0]     req_sample_value,
   input  logic                                    req_last_record,
   input  logic [ctfe_pkg::EVENT_INDEX_W-1:0]      req_event_index,
   input  logic [ctfe_pkg::SIGNAL_ID_W-1:0]        req_event_signal_id,
   input  logic [ctfe_pkg::OP_W-1:0]               req_event_op,
   input  logic signed [ctfe_pkg::VALUE_W-1:0]     req_event_limit,
   input  logic [ctfe_pkg::FRAME_ID_W-1:0]         req_event_frame_id,
   input  logic [ctfe_pkg::PAYLOAD_W-1:0]          req_event_payload,
   // Result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [ctfe_pkg::FRAME_ID_W-1:0]         rsp_frame_id,
   output logic [ctfe_pkg::PAYLOAD_W-1:0]          rsp_frame_payload,
   output logic                                    rsp_last_frame,
   // Control register write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ctfe_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ctfe_pkg::CSR_DATA_W-1:0]         csr_data
);

   import ctfe_pkg::*;

   localparam int SLOT_AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TBL_AW   = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
   localparam int TBL_CW   = $clog2(EVENT_COUNT + 2);
   localparam int CNT_W    = (SLOT_AW > TBL_CW) ? SLOT_AW : TBL_CW;
   localparam int ENTRY_W  = $bits(entry_type);
   localparam int SLOT_DW  = $bits(slot_type);

   ctrl_type   ctrl;
   status_type status;
   logic       req_fire;

   // Control registers.
   logic                     link_error_ff;
   logic [EVENT_COUNT_W-1:0] event_count_ff;

   // Captured request fields.
   logic [REQ_TYPE_W-1:0]        req_type_ff;
   logic [SLOT_W-1:0]            slot_ff;
   logic [SIGNAL_ID_W-1:0]       signal_id_ff;
   logic signed [VALUE_W-1:0]    sample_value_ff;
   logic [EVENT_INDEX_W-1:0]     event_index_ff;
   logic [SIGNAL_ID_W-1:0]       ev_signal_id_ff;
   logic [OP_W-1:0]              ev_op_ff;
   logic signed [VALUE_W-1:0]    ev_limit_ff;
   logic [FRAME_ID_W-1:0]        ev_frame_id_ff;
   logic [PAYLOAD_W-1:0]         ev_payload_ff;

   // Counter and scan results.
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic [CNT_W-1:0]       valid_n;
   logic [TBL_AW-1:0]      rd_idx_ff;
   logic [TBL_AW-1:0]      last_hit_ff;
   logic [EVENT_COUNT-1:0] hit_ff;
   logic                   matched_ff;
   logic                   any_hit_ff;
   logic                   id_match;
   logic                   entry_hit;
   logic                   changed;

   // Memory ports.
   entry_type              tbl_wr_data;
   entry_type              tbl_q;
   logic                   tbl_wr_en;
   slot_type               slot_wr_data;
   slot_type               slot_q;
   logic [SLOT_AW-1:0]     slot_wr_addr;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_load;
   logic [FRAME_ID_W-1:0]  rsp_frame_id_ff;
   logic [PAYLOAD_W-1:0]   rsp_frame_payload_ff;
   logic                   rsp_last_frame_ff;

   assign req_ready = ctrl.accept;
   assign req_fire  = req_valid && ctrl.accept;
   assign csr_ready = 1'b1;

   // Sequencer.
   ctfe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Control register writes; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_error_ff  <= 1'b0;
         event_count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LINK_ERROR:  link_error_ff  <= csr_data[0];
            CSR_EVENT_COUNT: event_count_ff <= csr_data[EVENT_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request transaction.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff     <= req_type;
         slot_ff         <= req_signal_slot;
         signal_id_ff    <= req_signal_id;
         sample_value_ff <= req_sample_value;
         event_index_ff  <= req_event_index;
         ev_signal_id_ff <= req_event_signal_id;
         ev_op_ff        <= req_event_op;
         ev_limit_ff     <= req_event_limit;
         ev_frame_id_ff  <= req_event_frame_id;
         ev_payload_ff   <= req_event_payload;
      end
   end

   // Valid entry count, saturated at the table depth.
   assign valid_n = (32'(event_count_ff) > 32'(EVENT_COUNT)) ? CNT_W'(EVENT_COUNT)
                                                            : CNT_W'(event_count_ff);

   // Step counter shared by the table passes and the slot sweep.
   always_comb begin
      if (ctrl.cnt_clr) begin
         cnt_in = '0;
      end else if (ctrl.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Event table memory.
   assign tbl_wr_en = ctrl.tbl_wr && (32'(event_index_ff) < 32'(EVENT_COUNT));

   always_comb begin
      tbl_wr_data.signal_id = ev_signal_id_ff;
      tbl_wr_data.op        = ev_op_ff;
      tbl_wr_data.limit     = ev_limit_ff;
      tbl_wr_data.frame_id  = ev_frame_id_ff;
      tbl_wr_data.payload   = ev_payload_ff;
   end

   ctfe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (EVENT_COUNT)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (TBL_AW'(event_index_ff)),
      .wr_data (tbl_wr_data),
      .rd_en   (ctrl.tbl_rd),
      .rd_addr (cnt_ff[TBL_AW-1:0]),
      .rd_data (tbl_q)
   );

   // Slot history memory: swept to first-sample state, or updated by a sample.
   always_comb begin
      if (ctrl.slot_clr) begin
         slot_wr_data.first = 1'b1;
         slot_wr_data.value = '0;
         slot_wr_addr       = cnt_ff[SLOT_AW-1:0];
      end else begin
         slot_wr_data.first = 1'b0;
         slot_wr_data.value = sample_value_ff;
         slot_wr_addr       = SLOT_AW'(slot_ff);
      end
   end

   ctfe_ram #(
      .WIDTH (SLOT_DW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ctrl.slot_wr || ctrl.slot_clr),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (ctrl.slot_rd),
      .rd_addr (SLOT_AW'(slot_ff)),
      .rd_data (slot_q)
   );

   // Per-entry test on the entry read in the previous step.
   assign id_match  = (tbl_q.signal_id == signal_id_ff);
   assign entry_hit = id_match && compare_holds(tbl_q.op, sample_value_ff, tbl_q.limit);
   assign changed   = slot_q.first || (slot_q.value != $unsigned(sample_value_ff));

   // Scan results: match flag, hit map and last firing entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff  <= 1'b0;
         any_hit_ff  <= 1'b0;
         hit_ff      <= '0;
         last_hit_ff <= '0;
         rd_idx_ff   <= '0;
      end else begin
         if (ctrl.tbl_rd) begin
            rd_idx_ff <= cnt_ff[TBL_AW-1:0];
         end
         if (ctrl.scan_init) begin
            matched_ff <= 1'b0;
            any_hit_ff <= 1'b0;
            hit_ff     <= '0;
         end else if (ctrl.eval) begin
            hit_ff[rd_idx_ff] <= entry_hit;
            if (id_match) begin
               matched_ff <= 1'b1;
            end
            if (entry_hit) begin
               any_hit_ff  <= 1'b1;
               last_hit_ff <= rd_idx_ff;
            end
         end
      end
   end

   // Status for the sequencer's jumps.
   always_comb begin
      status.req_fire   = req_fire;
      status.is_load    = (req_type_ff == REQ_LOAD);
      status.is_restart = (req_type_ff == REQ_RESTART);
      status.skip       = (req_type_ff != REQ_SAMPLE)
                          || (32'(slot_ff) >= 32'(SLOT_COUNT))
                          || (valid_n == '0);
      status.cnt_lt_n   = (cnt_ff < valid_n);
      status.no_match   = !matched_ff;
      status.no_emit    = !changed || link_error_ff || !any_hit_ff;
      status.not_last   = (rd_idx_ff != last_hit_ff);
      status.clr_more   = (cnt_ff != CNT_W'(SLOT_COUNT - 1));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Output register: loaded with a firing entry, emptied when taken.
   assign rsp_load = ctrl.emit && hit_ff[rd_idx_ff];

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_id_ff      <= tbl_q.frame_id;
         rsp_frame_payload_ff <= tbl_q.payload;
         rsp_last_frame_ff    <= (rd_idx_ff == last_hit_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_id      = rsp_frame_id_ff;
   assign rsp_frame_payload = rsp_frame_payload_ff;
   assign rsp_last_frame    = rsp_last_frame_ff;

   // Checks on the sequencer and datapath working together.
`include "change_triggered_frame_events_core_macros.svh"

   `CTFE_ASSERT_IMPLY(a_emit_has_room, clock, reset, ctrl.emit, !rsp_valid_ff || rsp_ready, "frame step ran while the output register was full")
   `CTFE_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_fire, !req_ready, "request taken again right after a transaction")
   `CTFE_ASSERT_IMPLY(a_hist_needs_match, clock, reset, ctrl.slot_wr, matched_ff, "slot history written for an unmatched signal")

endmodule

`default_nettype wire

/* verif/ctfe_frame_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and control register channels of the frame event
// core. It keeps its own copy of the slot history, the event table and the two
// control registers, works out the frames that each accepted request must
// cause, and compares every result transaction with the oldest frame still
// owed.
module ctfe_frame_checker (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [ctfe_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [ctfe_pkg::SLOT_W-1:0]         req_signal_slot,
   input  logic [ctfe_pkg::SIGNAL_ID_W-1:0]    req_signal_id,
   input  logic signed [ctfe_pkg::VALUE_W-1:0] req_sample_value,
   input  logic [ctfe_pkg::EVENT_INDEX_W-1:0]  req_event_index,
   input  logic [ctfe_pkg::SIGNAL_ID_W-1:0]    req_event_signal_id,
   input  logic [ctfe_pkg::OP_W-1:0]           req_event_op,
   input  logic signed [ctfe_pkg::VALUE_W-1:0] req_event_limit,
   input  logic [ctfe_pkg::FRAME_ID_W-1:0]     req_event_frame_id,
   input  logic [ctfe_pkg::PAYLOAD_W-1:0]      req_event_payload,
   // Result channel
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [ctfe_pkg::FRAME_ID_W-1:0]     rsp_frame_id,
   input  logic [ctfe_pkg::PAYLOAD_W-1:0]      rsp_frame_payload,
   input  logic                                rsp_last_frame,
   // Control register write channel
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [ctfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ctfe_pkg::CSR_DATA_W-1:0]     csr_data,
   // Status toward the testbench top
   output int                                  mismatch_count,
   output int                                  frames_waiting,
   output int                                  frames_checked
);

   import ctfe_pkg::*;

   localparam int SLOTS   = 64;
   localparam int ENTRIES = 16;

   // One frame that the core owes on the result channel.
   typedef struct {
      logic [FRAME_ID_W-1:0] frame_id;
      logic [PAYLOAD_W-1:0]  payload;
      logic                  last_frame;
   } frame_type;

   frame_type                pending_frames[$];
   slot_type                 slot_history [SLOTS];
   entry_type                event_table [ENTRIES];
   logic                     link_down;
   logic [EVENT_COUNT_W-1:0] entry_count_reg;
   int                       error_total;
   int                       checked_total;

   // Every slot starts over as if it had never seen a sample.
   task automatic clear_history();
      foreach (slot_history[s]) begin
         slot_history[s].first = 1'b1;
         slot_history[s].value = '0;
      end
   endtask

   // Signed test of a sample against the limit of one entry.
   // The two spare operation codes always hold.
   function automatic logic entry_fires(input entry_type ent,
                                        input logic signed [VALUE_W-1:0] sample);
      logic signed [VALUE_W-1:0] lim;
      lim = ent.limit;
      case (ent.op)
         OP_NE:   return sample != lim;
         OP_EQ:   return sample == lim;
         OP_LT:   return sample < lim;
         OP_LE:   return sample <= lim;
         OP_GT:   return sample > lim;
         OP_GE:   return sample >= lim;
         default: return 1'b1;
      endcase
   endfunction

   // Works out the frames of one accepted sample and queues them.
   task automatic predict_sample(input logic [SLOT_W-1:0] slot,
                                 input logic [SIGNAL_ID_W-1:0] sid,
                                 input logic signed [VALUE_W-1:0] sample);
      int        live;
      logic      matched;
      logic      changed;
      frame_type batch[$];
      frame_type one;
      live = (entry_count_reg > ENTRIES) ? ENTRIES : int'(entry_count_reg);
      matched = 1'b0;
      for (int e = 0; e < live; e++)
         if (event_table[e].signal_id == sid)
            matched = 1'b1;
      // A signal that no live entry watches leaves the history alone.
      if (!matched)
         return;
      changed = slot_history[slot].first || (slot_history[slot].value != sample);
      slot_history[slot].first = 1'b0;
      slot_history[slot].value = sample;
      // The history moves on even while the link is down.
      if (!changed || link_down)
         return;
      for (int e = 0; e < live; e++) begin
         if (event_table[e].signal_id == sid && entry_fires(event_table[e], sample)) begin
            one.frame_id   = event_table[e].frame_id;
            one.payload    = event_table[e].payload;
            one.last_frame = 1'b0;
            batch = {batch, one};
         end
      end
      if (batch.size() > 0)
         batch[batch.size()-1].last_frame = 1'b1;
      foreach (batch[i])
         pending_frames = {pending_frames, batch[i]};
   endtask

   // Compares one result transaction with the oldest frame owed.
   task automatic check_frame();
      frame_type want;
      logic      bad;
      if (pending_frames.size() == 0) begin
         $error("unexpected frame: frame_id %h, payload %h, last_frame %b",
                rsp_frame_id, rsp_frame_payload, rsp_last_frame);
         error_total++;
         return;
      end
      want = pending_frames.pop_front();
      checked_total++;
      bad = 1'b0;
      if (rsp_frame_id !== want.frame_id) begin
         $error("frame_id mismatch: expected %h, actual %h", want.frame_id, rsp_frame_id);
         bad = 1'b1;
      end
      if (rsp_frame_payload !== want.payload) begin
         $error("frame_payload mismatch: expected %h, actual %h",
                want.payload, rsp_frame_payload);
         bad = 1'b1;
      end
      if (rsp_last_frame !== want.last_frame) begin
         $error("last_frame mismatch: expected %b, actual %b",
                want.last_frame, rsp_last_frame);
         bad = 1'b1;
      end
      if (bad)
         error_total++;
   endtask

   // Results are checked before new requests are predicted, so a frame taken
   // at the same edge as a request always belongs to an earlier one.
   always @(posedge clock) begin
      if (reset) begin
         clear_history();
         link_down = 1'b0;
         entry_count_reg = '0;
         pending_frames.delete();
         error_total = 0;
         checked_total = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_frame();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINK_ERROR:  link_down = csr_data[0];
               CSR_EVENT_COUNT: entry_count_reg = csr_data[EVENT_COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_SAMPLE: predict_sample(req_signal_slot, req_signal_id, req_sample_value);
               REQ_LOAD: begin
                  event_table[req_event_index].signal_id = req_event_signal_id;
                  event_table[req_event_index].op        = req_event_op;
                  event_table[req_event_index].limit     = req_event_limit;
                  event_table[req_event_index].frame_id  = req_event_frame_id;
                  event_table[req_event_index].payload   = req_event_payload;
               end
               REQ_RESTART: clear_history();
               default: ;
            endcase
         end
      end
      mismatch_count <= error_total;
      frames_waiting <= pending_frames.size();
      frames_checked <= checked_total;
   end

endmodule

/* verif/change_triggered_frame_events_core_tb.sv */
`timescale 1ns / 1ps

// Drives samples, entry loads and restarts into the frame event core, writes
// the control registers between phases, and lets the checker beside the core
// judge every frame that comes out.
module change_triggered_frame_events_core_tb;

   import ctfe_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 600;

   // Codes the core is expected to ignore or to treat as always true.
   localparam logic [REQ_TYPE_W-1:0]  REQ_UNUSED   = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [OP_W-1:0]        OP_SPARE_LO  = 3'd6;
   localparam logic [OP_W-1:0]        OP_SPARE_HI  = 3'd7;

   // Full content of one request transaction.
   typedef struct {
      logic [REQ_TYPE_W-1:0]    kind;
      logic [SLOT_W-1:0]        slot;
      logic [SIGNAL_ID_W-1:0]   signal_id;
      logic [VALUE_W-1:0]       value;
      logic                     last_record;
      logic [EVENT_INDEX_W-1:0] index;
      logic [SIGNAL_ID_W-1:0]   entry_id;
      logic [OP_W-1:0]          op;
      logic [VALUE_W-1:0]       limit;
      logic [FRAME_ID_W-1:0]    frame_id;
      logic [PAYLOAD_W-1:0]     payload;
   } request_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [REQ_TYPE_W-1:0]         req_type;
   logic [SLOT_W-1:0]             req_signal_slot;
   logic [SIGNAL_ID_W-1:0]        req_signal_id;
   logic signed [VALUE_W-1:0]     req_sample_value;
   logic                          req_last_record;
   logic [EVENT_INDEX_W-1:0]      req_event_index;
   logic [SIGNAL_ID_W-1:0]        req_event_signal_id;
   logic [OP_W-1:0]               req_event_op;
   logic signed [VALUE_W-1:0]     req_event_limit;
   logic [FRAME_ID_W-1:0]         req_event_frame_id;
   logic [PAYLOAD_W-1:0]          req_event_payload;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [FRAME_ID_W-1:0]         rsp_frame_id;
   logic [PAYLOAD_W-1:0]          rsp_frame_payload;
   logic                          rsp_last_frame;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   int                            mismatch_count;
   int                            frames_waiting;
   int                            frames_checked;

   int                            cycle_count;
   int                            steady_items;
   int                            samples_sent;
   int                            loads_sent;
   int                            restarts_sent;
   int                            ignored_sent;
   logic                          hold_request;
   logic                          hold_done;
   logic [SIGNAL_ID_W-1:0]        watched_ids [4];

   change_triggered_frame_events_core dut (.*);

   ctfe_frame_checker frame_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // Hard stop in case the core hangs or drops frames.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d frames outstanding.",
               cycle_count, frames_waiting);
      $display("status: fail");
      $finish;
   end

   // Sender gap in cycles before the next request: mostly none or short,
   // now and then long, with runs of back-to-back requests.
   function automatic int next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_items > 0) begin
         steady_items--;
         return 0;
      end
      if (pick < 6) begin
         steady_items = $urandom_range(15, 40);
         return 0;
      end
      if (pick < 55)
         return 0;
      if (pick < 88)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Signal ids mostly come from the few that the table watches.
   function automatic logic [SIGNAL_ID_W-1:0] pick_id();
      logic [31:0] w;
      w = $urandom;
      if (w[3:0] < 4'd14)
         return watched_ids[w[5:4]];
      return $urandom;
   endfunction

   // Values favor the extremes and a few repeats so that unchanged samples
   // and exact limit hits are common.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'h0001_0000;
         4: return 32'hFFFF_0000;
         5: return 32'hFFFF_FFFF;
         6: return {16'd0, w[1:0], 14'd0};
         default: return w;
      endcase
   endfunction

   // A request of the given kind with random content in every field.
   function automatic request_type junk_request(input logic [REQ_TYPE_W-1:0] kind);
      request_type r;
      logic [31:0] a;
      a = $urandom;
      r.kind        = kind;
      r.slot        = a[5:0];
      r.index       = a[9:6];
      r.op          = a[12:10];
      r.last_record = a[13];
      r.signal_id   = $urandom;
      r.value       = $urandom;
      r.entry_id    = $urandom;
      r.limit       = $urandom;
      a = $urandom;
      r.frame_id    = a[28:0];
      r.payload     = {$urandom, $urandom};
      return r;
   endfunction

   // Offers one request transaction and holds it until it is taken.
   task automatic send_request(input request_type r);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= r.kind;
      req_signal_slot     <= r.slot;
      req_signal_id       <= r.signal_id;
      req_sample_value    <= r.value;
      req_last_record     <= r.last_record;
      req_event_index     <= r.index;
      req_event_signal_id <= r.entry_id;
      req_event_op        <= r.op;
      req_event_limit     <= r.limit;
      req_event_frame_id  <= r.frame_id;
      req_event_payload   <= r.payload;
      do @(posedge clock); while (!req_ready);
      case (r.kind)
         REQ_SAMPLE:  samples_sent++;
         REQ_LOAD:    loads_sent++;
         REQ_RESTART: restarts_sent++;
         default:     ignored_sent++;
      endcase
   endtask

   task automatic send_sample(input logic [SLOT_W-1:0] slot,
                              input logic [SIGNAL_ID_W-1:0] sid,
                              input logic [VALUE_W-1:0] value);
      request_type r;
      r = junk_request(REQ_SAMPLE);
      r.slot      = slot;
      r.signal_id = sid;
      r.value     = value;
      send_request(r);
   endtask

   task automatic send_load(input logic [EVENT_INDEX_W-1:0] index,
                            input logic [SIGNAL_ID_W-1:0] sid,
                            input logic [OP_W-1:0] op,
                            input logic [VALUE_W-1:0] limit,
                            input logic [31:0] frame_word,
                            input logic [PAYLOAD_W-1:0] payload);
      request_type r;
      r = junk_request(REQ_LOAD);
      r.index    = index;
      r.entry_id = sid;
      r.op       = op;
      r.limit    = limit;
      r.frame_id = frame_word[FRAME_ID_W-1:0];
      r.payload  = payload;
      send_request(r);
   endtask

   // Waits until every owed frame has come and the core has had time to
   // finish any request that causes no frame.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Writes both registers once the core is idle; unused data bits are random.
   task automatic configure(input logic link, input logic [EVENT_COUNT_W-1:0] count);
      logic [31:0] w;
      wait_idle();
      w = $urandom;
      w[0] = link;
      write_register(CSR_LINK_ERROR, w[CSR_DATA_W-1:0]);
      w = $urandom;
      w[EVENT_COUNT_W-1:0] = count;
      write_register(CSR_EVENT_COUNT, w[CSR_DATA_W-1:0]);
   endtask

   // One random phase under a fixed register setting. Most requests are
   // samples on a few slots and watched ids; the rest reload entries,
   // restart the history or carry the unused request code.
   task automatic random_phase(input logic link, input logic [EVENT_COUNT_W-1:0] count,
                               input int items);
      int          done;
      int          pick;
      logic [31:0] w;
      logic [31:0] x;
      configure(link, count);
      done = 0;
      while (done < items) begin
         pick = $urandom_range(0, 99);
         w = $urandom;
         x = $urandom;
         if (pick < 72) begin
            send_sample((w[7:6] != 2'b11) ? {4'd0, w[1:0]} : w[13:8], pick_id(),
                        pick_value());
            done++;
         end else if (pick < 87) begin
            send_load(w[3:0], pick_id(), w[6:4], pick_value(), x, {$urandom, $urandom});
            done++;
         end else if (pick < 93) begin
            send_request(junk_request(REQ_RESTART));
            done++;
         end else begin
            send_request(junk_request(REQ_UNUSED));
         end
      end
   endtask

   // Result side: random stalls, stretches without any, and one long hold
   // while the sender keeps offering so that the core backs up.
   initial begin : result_sink
      int stall_left;
      int free_left;
      int hold_left;
      int pick;
      stall_left = 0;
      free_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         pick = $urandom_range(0, 99);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_ready <= 1'b1;
            free_left--;
         end else if (pick < 8) begin
            rsp_ready <= 1'b1;
            free_left = $urandom_range(30, 80);
         end else if (pick < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            if (pick < 92)
               stall_left = $urandom_range(0, 2);
            else if (pick < 98)
               stall_left = $urandom_range(3, 10);
            else
               stall_left = $urandom_range(15, 40);
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_type            <= REQ_SAMPLE;
      req_signal_slot     <= '0;
      req_signal_id       <= '0;
      req_sample_value    <= '0;
      req_last_record     <= 1'b0;
      req_event_index     <= '0;
      req_event_signal_id <= '0;
      req_event_op        <= OP_NE;
      req_event_limit     <= '0;
      req_event_frame_id  <= '0;
      req_event_payload   <= '0;
      csr_valid           <= 1'b0;
      csr_index           <= CSR_LINK_ERROR;
      csr_data            <= '0;
      hold_request        <= 1'b0;
      steady_items         = 0;
      samples_sent         = 0;
      loads_sent           = 0;
      restarts_sent        = 0;
      ignored_sent         = 0;
      watched_ids[0]       = 32'h0000_0000;
      watched_ids[1]       = 32'hFFFF_FFFF;
      watched_ids[2]       = $urandom;
      watched_ids[3]       = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Register writes right after reset, including the unused indexes.
      configure(1'b0, 5'd0);
      write_register(CSR_SPARE_LO, 8'hFF);
      write_register(CSR_SPARE_HI, 8'h5A);

      // With no live entry nothing can match.
      send_sample(6'd0, 32'hFFFF_FFFF, 32'h0000_0000);

      // Fill the whole table before any entry becomes live. The first eight
      // entries cover every operation code, the rest are random.
      send_load(4'd0, 32'h0000_0000, OP_NE, 32'h0000_0000, 32'h0, 64'h0);
      send_load(4'd1, 32'h0000_0000, OP_EQ, 32'h8000_0000, 32'h1FFF_FFFF, '1);
      send_load(4'd2, 32'hFFFF_FFFF, OP_LT, 32'h0, $urandom, {$urandom, $urandom});
      send_load(4'd3, 32'hFFFF_FFFF, OP_LE, 32'h0, $urandom, {$urandom, $urandom});
      send_load(4'd4, 32'hFFFF_FFFF, OP_GT, 32'h0, $urandom, {$urandom, $urandom});
      send_load(4'd5, 32'hFFFF_FFFF, OP_GE, 32'h0, $urandom, {$urandom, $urandom});
      send_load(4'd6, 32'hFFFF_FFFF, OP_SPARE_LO, $urandom, $urandom, {$urandom, $urandom});
      send_load(4'd7, 32'hFFFF_FFFF, OP_SPARE_HI, $urandom, $urandom, {$urandom, $urandom});
      for (int e = 8; e < 16; e++)
         send_load(e[3:0], pick_id(), 3'($urandom_range(0, 7)), pick_value(), $urandom,
                   {$urandom, $urandom});
      configure(1'b0, 5'd16);

      // First sample, an unchanged repeat, then both value extremes.
      send_sample(6'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_sample(6'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_sample(6'd0, 32'hFFFF_FFFF, 32'h8000_0000);
      send_sample(6'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_sample(6'd63, 32'h0000_0000, 32'h8000_0000);
      // A signal that no entry watches.
      send_sample(6'd1, 32'h1234_5679, 32'h0002_0000);
      // After a restart the same value counts as a first sample again.
      send_request(junk_request(REQ_RESTART));
      send_sample(6'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_request(junk_request(REQ_UNUSED));

      // Link error mutes frames, but the history still moves on.
      configure(1'b1, 5'd16);
      send_sample(6'd2, 32'hFFFF_FFFF, 32'h0000_0005);
      configure(1'b0, 5'd16);
      send_sample(6'd2, 32'hFFFF_FFFF, 32'h0000_0005);
      send_sample(6'd2, 32'hFFFF_FFFF, 32'h0000_0006);

      // Counts above the table size saturate; a small count hides entries.
      configure(1'b0, 5'd31);
      send_sample(6'd4, 32'h0000_0000, 32'h0001_0000);
      configure(1'b0, 5'd2);
      send_sample(6'd3, 32'hFFFF_FFFF, 32'h0000_0001);
      send_sample(6'd5, 32'h0000_0000, 32'h8000_0000);

      // Random phases; the long output hold falls in the first one.
      hold_request <= 1'b1;
      random_phase(1'b0, 5'd16, 45);
      random_phase(1'b0, 5'd31, 30);
      random_phase(1'b1, 5'd16, 12);
      random_phase(1'b0, 5'd6, 20);
      random_phase(1'b0, 5'd16, 20);
      wait_idle();

      $display("Sent %0d samples, %0d entry loads, %0d restarts and %0d ignored requests;",
               samples_sent, loads_sent, restarts_sent, ignored_sent);
      $display("checked %0d frames across link error on and off and event counts 0 to 31.",
               frames_checked);
      if (mismatch_count == 0 && frames_waiting == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
